// ===== rtl/aesc_pkg.sv =====
// Shared types and constants for the arithmetic expression syntax checker.
// No dependencies; imported by the front end, back end and top level.
package aesc_pkg;

   localparam int MAX_DEPTH_DEFAULT = 255;
   localparam int TOKEN_QUEUE_DEPTH = 2;
   localparam int RESULT_QUEUE_DEPTH = 2;

   // Character codes of the accepted set
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_DOT     = 8'h2E;
   localparam logic [7:0] CH_EXP     = 8'h65;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_OPEN    = 8'h28;
   localparam logic [7:0] CH_CLOSE   = 8'h29;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_STAR    = 8'h2A;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_PERCENT = 8'h25;

   typedef enum logic [3:0] {
      CLS_SPACE,
      CLS_DIGIT,
      CLS_DOT,
      CLS_EXP,
      CLS_OPEN,
      CLS_CLOSE,
      CLS_PLUS,
      CLS_MINUS,
      CLS_MULOP,
      CLS_BAD,
      CLS_END
   } char_class_type;

   typedef struct packed {
      char_class_type cls;
   } token_type;

   typedef enum logic [1:0] {
      VERDICT_BUSY     = 2'd0,
      VERDICT_VALID    = 2'd1,
      VERDICT_REJECTED = 2'd2
   } verdict_type;

   typedef enum logic [3:0] {
      ERR_NONE          = 4'd0,
      ERR_NUM_EXPECTED  = 4'd1,
      ERR_SYNTAX        = 4'd2,
      ERR_BAD_NUMBER    = 4'd3,
      ERR_OP_MISS_NUM   = 4'd4,
      ERR_OP_BEF_CLOSE  = 4'd5,
      ERR_BAD_CLOSE     = 4'd6,
      ERR_EMPTY_PARENS  = 4'd7,
      ERR_OP_MISS_OPEN  = 4'd8,
      ERR_ADJACENT_OPS  = 4'd9,
      ERR_MISMATCH      = 4'd10,
      ERR_TRAILING_OP   = 4'd11,
      ERR_TOO_DEEP      = 4'd12
   } error_type;

   typedef struct packed {
      verdict_type verdict;
      error_type   error_code;
      logic        expr_done;
   } result_type;

endpackage

// ===== rtl/aesc_front.sv =====
// Front end: sorts each incoming character into a token class.
// Depends on aesc_pkg.
module aesc_front (
   input  logic [7:0]         char_code,
   input  logic               end_marker,
   output aesc_pkg::token_type token
);
   import aesc_pkg::*;

   always_comb begin
      token.cls = CLS_BAD;
      if (end_marker) begin
         token.cls = CLS_END;
      end else if (char_code >= CH_ZERO && char_code <= CH_NINE) begin
         token.cls = CLS_DIGIT;
      end else begin
         unique case (char_code)
            CH_DOT:                     token.cls = CLS_DOT;
            CH_EXP:                     token.cls = CLS_EXP;
            CH_SPACE, CH_NEWLINE:       token.cls = CLS_SPACE;
            CH_OPEN:                    token.cls = CLS_OPEN;
            CH_CLOSE:                   token.cls = CLS_CLOSE;
            CH_PLUS:                    token.cls = CLS_PLUS;
            CH_MINUS:                   token.cls = CLS_MINUS;
            CH_STAR, CH_SLASH, CH_PERCENT: token.cls = CLS_MULOP;
            default:                    token.cls = CLS_BAD;
         endcase
      end
   end

endmodule

// ===== rtl/aesc_queue.sv =====
// Small first-in first-out queue of register entries.
// No dependencies; its width and depth are parameters handed in by its user.
module aesc_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             rd_en,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [AW:0]      count_ff, count_in;
   logic             do_wr, do_rd;

   assign full    = (count_ff == (AW+1)'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ===== rtl/aesc_back.sv =====
// Back end (uses aesc_pkg): runs syntax state (number flags, nesting depth,
// latched error) on one token per cycle unless res_full; forms the result item.
module aesc_back #(
   parameter int MAX_DEPTH = aesc_pkg::MAX_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  tok_valid,
   input  aesc_pkg::token_type   token,
   output logic                  tok_take,
   input  logic                  res_full,
   output logic                  res_push,
   output aesc_pkg::result_type  result
);
   import aesc_pkg::*;

   // Counter is 8 bits wide, so the limit saturates at 255
   localparam logic [7:0] DEPTH_LIMIT = 8'((MAX_DEPTH > 255) ? 255 : MAX_DEPTH);

   logic       in_number_ff, in_number_in;
   logic       seen_decimal_ff, seen_decimal_in;
   logic       seen_exponent_ff, seen_exponent_in;
   logic       digit_required_ff, digit_required_in;
   logic       number_was_last_ff, number_was_last_in;
   logic       prev_was_open_ff, prev_was_open_in;
   logic [7:0] depth_ff, depth_in;
   error_type  latched_ff, latched_in;

   logic       step;

   assign step     = tok_valid && !res_full;
   assign tok_take = step;
   assign res_push = step;

   always_comb begin
      logic      in_num, sd, se, dr, nwl;
      logic [7:0] dep;
      error_type err;

      in_num = in_number_ff;
      sd     = seen_decimal_ff;
      se     = seen_exponent_ff;
      dr     = digit_required_ff;
      nwl    = number_was_last_ff;
      dep    = depth_ff;
      err    = ERR_NONE;

      in_number_in       = in_number_ff;
      seen_decimal_in    = seen_decimal_ff;
      seen_exponent_in   = seen_exponent_ff;
      digit_required_in  = digit_required_ff;
      number_was_last_in = number_was_last_ff;
      prev_was_open_in   = prev_was_open_ff;
      depth_in           = depth_ff;
      latched_in         = latched_ff;
      result.verdict     = VERDICT_BUSY;
      result.error_code  = ERR_NONE;
      result.expr_done   = 1'b0;

      if (token.cls == CLS_END) begin
         err = latched_ff;
         if (err == ERR_NONE) begin
            if (in_num) begin
               nwl = 1'b1;
            end else if (dr) begin
               err = ERR_NUM_EXPECTED;
            end
            if (err == ERR_NONE) begin
               if (dep != '0) begin
                  err = ERR_MISMATCH;
               end else if (!nwl) begin
                  err = ERR_TRAILING_OP;
               end
            end
         end
         result.verdict     = (err == ERR_NONE) ? VERDICT_VALID : VERDICT_REJECTED;
         result.error_code  = err;
         result.expr_done   = 1'b1;
         in_number_in       = 1'b0;
         seen_decimal_in    = 1'b0;
         seen_exponent_in   = 1'b0;
         digit_required_in  = 1'b0;
         number_was_last_in = 1'b0;
         prev_was_open_in   = 1'b0;
         depth_in           = '0;
         latched_in         = ERR_NONE;
      end else begin
         // Once an error has latched, later state changes are dead: only the
         // end marker (or reset) clears the latched error.
         unique case (token.cls)
            CLS_SPACE: begin
               if (dr) begin
                  err = ERR_NUM_EXPECTED;
               end else if (in_num) begin
                  in_num = 1'b0; sd = 1'b0; se = 1'b0; nwl = 1'b1;
               end
            end
            CLS_DIGIT: begin
               dr = 1'b0;
               if (nwl) begin
                  err = ERR_OP_MISS_NUM;
               end
               in_num = 1'b1;
            end
            CLS_DOT: begin
               dr = 1'b0;
               if (!in_num) begin
                  err = ERR_SYNTAX;
               end else if (sd) begin
                  err = ERR_BAD_NUMBER;
               end else if (nwl) begin
                  err = ERR_OP_MISS_NUM;
               end
               sd     = 1'b1;
               in_num = 1'b1;
            end
            CLS_EXP: begin
               if (se) begin
                  err = ERR_BAD_NUMBER;
               end else if (nwl) begin
                  err = ERR_OP_MISS_NUM;
               end
               se     = 1'b1;
               dr     = 1'b1;
               in_num = 1'b1;
            end
            CLS_CLOSE: begin
               if (in_num) begin
                  in_num = 1'b0; sd = 1'b0; se = 1'b0; nwl = 1'b1;
               end
               priority if (dr) begin
                  err = ERR_NUM_EXPECTED;
               end else if (!nwl) begin
                  err = ERR_OP_BEF_CLOSE;
               end else if (dep == '0) begin
                  err = ERR_BAD_CLOSE;
               end else if (prev_was_open_ff) begin
                  err = ERR_EMPTY_PARENS;
               end else begin
                  dep = dep - 1'b1;
               end
            end
            CLS_OPEN: begin
               if (in_num) begin
                  in_num = 1'b0; sd = 1'b0; se = 1'b0; nwl = 1'b1;
               end
               priority if (dr) begin
                  err = ERR_NUM_EXPECTED;
               end else if (nwl) begin
                  err = ERR_OP_MISS_OPEN;
               end else if (dep >= DEPTH_LIMIT) begin
                  err = ERR_TOO_DEEP;
               end else begin
                  dep = dep + 1'b1;
                  nwl = 1'b0;
               end
            end
            CLS_PLUS, CLS_MINUS, CLS_MULOP: begin
               if (token.cls == CLS_MINUS && in_num && se) begin
                  // sign of an exponent
                  dr = 1'b1;
               end else if (dr) begin
                  err = ERR_NUM_EXPECTED;
               end else begin
                  if (in_num) begin
                     in_num = 1'b0; sd = 1'b0; se = 1'b0; nwl = 1'b1;
                  end
                  if (token.cls == CLS_MULOP && !nwl) begin
                     err = ERR_ADJACENT_OPS;
                  end
                  nwl = 1'b0;
               end
            end
            default: begin
               err = ERR_SYNTAX;
            end
         endcase

         if (latched_ff == ERR_NONE) begin
            in_number_in       = in_num;
            seen_decimal_in    = sd;
            seen_exponent_in   = se;
            digit_required_in  = dr;
            number_was_last_in = nwl;
            depth_in           = dep;
            latched_in         = err;
            prev_was_open_in   = (token.cls == CLS_OPEN);
         end
         result.verdict    = (latched_in == ERR_NONE) ? VERDICT_BUSY : VERDICT_REJECTED;
         result.error_code = latched_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_number_ff       <= 1'b0;
         seen_decimal_ff    <= 1'b0;
         seen_exponent_ff   <= 1'b0;
         digit_required_ff  <= 1'b0;
         number_was_last_ff <= 1'b0;
         prev_was_open_ff   <= 1'b0;
         depth_ff           <= '0;
         latched_ff         <= ERR_NONE;
      end else if (step) begin
         in_number_ff       <= in_number_in;
         seen_decimal_ff    <= seen_decimal_in;
         seen_exponent_ff   <= seen_exponent_in;
         digit_required_ff  <= digit_required_in;
         number_was_last_ff <= number_was_last_in;
         prev_was_open_ff   <= prev_was_open_in;
         depth_ff           <= depth_in;
         latched_ff         <= latched_in;
      end
   end

endmodule

// ===== rtl/arith_expression_syntax_checker_core.sv =====
// Top level of the arithmetic expression syntax checker: front classifier,
// token queue, back-end checker and result queue. Depends on aesc_pkg.
//
//   channel   handshake      payload
//   request   push / full    req_char_code[7:0], req_end_marker
//   response  empty / pop    rsp_verdict[1:0], rsp_error_code[3:0], rsp_expr_done
//
// One item per cycle sustained while results are popped; an accepted item is
// registered in the token queue, checked from there by the back end, and its
// result written into the result queue, which drives the response ports.
// The back end steps once per cycle while a token waits and the result queue
// has room; a stalled response side backs up into full after both queues fill.
// Synchronous reset empties both queues and clears all checker state.
module arith_expression_syntax_checker_core #(
   parameter int MAX_DEPTH = aesc_pkg::MAX_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic [7:0] req_char_code,
   input  logic       req_end_marker,
   input  logic       push,
   output logic       full,
   output logic [1:0] rsp_verdict,
   output logic [3:0] rsp_error_code,
   output logic       rsp_expr_done,
   output logic       empty,
   input  logic       pop
);
   import aesc_pkg::*;

   token_type  front_token;
   token_type  back_token;
   logic       tok_empty;
   logic       tok_take;
   logic       res_full;
   logic       res_push;
   result_type back_result;
   result_type out_result;

   aesc_front u_front (
      .char_code  (req_char_code),
      .end_marker (req_end_marker),
      .token      (front_token)
   );

   aesc_queue #(
      .WIDTH ($bits(token_type)),
      .DEPTH (TOKEN_QUEUE_DEPTH)
   ) u_tok_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (push),
      .wr_data (front_token),
      .full    (full),
      .rd_en   (tok_take),
      .rd_data (back_token),
      .empty   (tok_empty)
   );

   aesc_back #(
      .MAX_DEPTH (MAX_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .tok_valid (!tok_empty),
      .token     (back_token),
      .tok_take  (tok_take),
      .res_full  (res_full),
      .res_push  (res_push),
      .result    (back_result)
   );

   aesc_queue #(
      .WIDTH ($bits(result_type)),
      .DEPTH (RESULT_QUEUE_DEPTH)
   ) u_res_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (res_push),
      .wr_data (back_result),
      .full    (res_full),
      .rd_en   (pop),
      .rd_data (out_result),
      .empty   (empty)
   );

   assign rsp_verdict    = out_result.verdict;
   assign rsp_error_code = out_result.error_code;
   assign rsp_expr_done  = out_result.expr_done;

endmodule
